FILE: src/info_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// info_frame_receiver_assert: assertion macros for the frame receiver.
// Each macro expands to a labeled concurrent assertion on clk, or to nothing
// when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef INFO_FRAME_RECEIVER_ASSERT_SVH
`define INFO_FRAME_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property checked only while reset is released.
`define IFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Property checked at every clock edge, reset included.
`define IFR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`else

`define IFR_ASSERT(lbl, prop)
`define IFR_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

FILE: src/ifr_pkg.sv
// ----------------------------------------------------------------------------
// ifr_pkg: shared types and constants of the info frame receiver.
// Byte codes, result kinds, register indexes, phase type and the item that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package ifr_pkg;

  // Special byte values on the line.
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;
  localparam logic [1:0] KIND_BAD_ESC = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ADDRESS  = 2'd0;
  localparam logic [1:0] CFG_SEQ_ZERO = 2'd1;
  localparam logic [1:0] CFG_SEQ_ONE  = 2'd2;

  // Configuration reset values.
  localparam logic [7:0] RST_ADDRESS  = 8'd3;
  localparam logic [7:0] RST_SEQ_ZERO = 8'd0;
  localparam logic [7:0] RST_SEQ_ONE  = 8'd64;

  // Receiver phase.
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_FLAG = 3'd1,
    PH_ADDR = 3'd2,
    PH_CTRL = 3'd3,
    PH_DATA = 3'd4,
    PH_ESC  = 3'd5
  } phase_t;

  // Classified byte handed from the front end to the back end.
  typedef struct packed {
    logic [7:0] data;
    logic       is_flag;
    logic       is_esc;
    logic       is_esc_flag;
    logic       is_esc_esc;
  } ifr_item_t;

  // Configuration register set.
  typedef struct packed {
    logic [7:0] address;
    logic [7:0] seq_zero;
    logic [7:0] seq_one;
  } ifr_cfg_t;

endpackage

FILE: src/ifr_front.sv
// ----------------------------------------------------------------------------
// ifr_front: input stage of the info frame receiver.
// Takes one received byte per transfer, tags the special byte codes and
// holds the classified item until the queue takes it.
// ----------------------------------------------------------------------------
module ifr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  output logic              item_vld,
  input  logic              item_ready,
  output ifr_pkg::ifr_item_t item
);
  import ifr_pkg::*;

  logic      vld_r;
  logic      vld_nxt;
  ifr_item_t item_r;
  ifr_item_t item_nxt;

  // The stage is free when empty or when its item leaves this cycle.
  assign in_ready = !vld_r || item_ready;
  assign item_vld = vld_r;
  assign item     = item_r;

  // Byte classification.
  always_comb begin
    item_nxt.data        = in_rx_byte;
    item_nxt.is_flag     = (in_rx_byte == FLAG_BYTE);
    item_nxt.is_esc      = (in_rx_byte == ESC_BYTE);
    item_nxt.is_esc_flag = (in_rx_byte == ESC_FLAG);
    item_nxt.is_esc_esc  = (in_rx_byte == ESC_ESC);
  end

  // Occupancy of the stage.
  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (item_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: src/ifr_queue.sv
// ----------------------------------------------------------------------------
// ifr_queue: two-entry queue between front end and back end.
// Lets either side stall on its own while the other keeps moving.
// ----------------------------------------------------------------------------
`include "info_frame_receiver_assert.svh"

module ifr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_vld,
  output logic               push_ready,
  input  ifr_pkg::ifr_item_t push_item,
  output logic               pop_vld,
  input  logic               pop_ready,
  output ifr_pkg::ifr_item_t pop_item
);
  import ifr_pkg::*;

  ifr_item_t  entry_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;
  logic       pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_vld    = (cnt_r != 2'd0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign push       = push_vld && push_ready;
  assign pop        = pop_vld && pop_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  `IFR_ASSERT(a_cnt_range, cnt_r <= 2'd2)
  `IFR_ASSERT(a_full_ptrs, (cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
  `IFR_ASSERT(a_empty_ptrs, (cnt_r == 2'd0) |-> (wr_ptr_r == rd_ptr_r))

endmodule

FILE: src/ifr_back.sv
// ----------------------------------------------------------------------------
// ifr_back: frame state machine and result register.
// Checks the header, removes byte stuffing, delays payload bytes by one so
// the last one serves as the block check, and reports the frame verdict.
// ----------------------------------------------------------------------------
`include "info_frame_receiver_assert.svh"

module ifr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ifr_pkg::ifr_cfg_t  cfg,
  input  logic               item_vld,
  output logic               item_ready,
  input  ifr_pkg::ifr_item_t item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_result_kind,
  output logic [7:0]         out_payload_byte,
  output logic               out_reply_seq
);
  import ifr_pkg::*;

  phase_t     phase_r;
  phase_t     phase_nxt;
  logic       frame_seq_r;
  logic       frame_seq_nxt;
  logic [7:0] held_byte_r;
  logic [7:0] held_byte_nxt;
  logic       held_valid_r;
  logic       held_valid_nxt;
  logic [7:0] xor_r;
  logic [7:0] xor_nxt;
  logic       out_vld_r;
  logic       out_vld_nxt;
  logic [1:0] kind_r;
  logic [7:0] byte_r;
  logic       seq_r;

  logic       pop;
  logic       hdr_ok;
  logic       take;
  logic [7:0] take_byte;
  logic       res_vld;
  logic [1:0] res_kind;
  logic [7:0] res_byte;
  logic       res_seq;

  // An item moves on when the result register is free or being emptied.
  assign item_ready = !out_vld_r || out_ready;
  assign pop        = item_vld && item_ready;

  // Header check against the control byte that matched.
  assign hdr_ok = (item.data ==
                   (cfg.address ^ (frame_seq_r ? cfg.seq_zero : cfg.seq_one)));

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (pop) begin
      unique case (phase_r)
        PH_FLAG: begin
          if (item.data == cfg.address) begin
            phase_nxt = PH_ADDR;
          end else if (item.is_flag) begin
            phase_nxt = PH_FLAG;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_ADDR: begin
          if (item.data == cfg.seq_zero || item.data == cfg.seq_one) begin
            phase_nxt = PH_CTRL;
          end else if (item.is_flag) begin
            phase_nxt = PH_FLAG;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_CTRL: begin
          if (hdr_ok) begin
            phase_nxt = PH_DATA;
          end else if (item.is_flag) begin
            phase_nxt = PH_FLAG;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_DATA: begin
          if (item.is_flag) begin
            phase_nxt = PH_HUNT;
          end else if (item.is_esc) begin
            phase_nxt = PH_ESC;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_ESC: begin
          if (item.is_esc_flag || item.is_esc_esc) begin
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        default: begin
          phase_nxt = item.is_flag ? PH_FLAG : PH_HUNT;
        end
      endcase
    end
  end

  // Results and data path updates for the item at hand.
  always_comb begin
    res_vld        = 1'b0;
    res_kind       = KIND_PAYLOAD;
    res_byte       = 8'd0;
    res_seq        = 1'b0;
    frame_seq_nxt  = frame_seq_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    xor_nxt        = xor_r;
    take           = 1'b0;
    take_byte      = item.data;
    unique case (phase_r)
      PH_ADDR: begin
        if (item.data == cfg.seq_zero) begin
          frame_seq_nxt = 1'b1;
        end else if (item.data == cfg.seq_one) begin
          frame_seq_nxt = 1'b0;
        end
      end
      PH_CTRL: begin
        if (hdr_ok) begin
          held_byte_nxt  = 8'd0;
          held_valid_nxt = 1'b0;
          xor_nxt        = 8'd0;
        end
      end
      PH_DATA: begin
        if (item.is_flag) begin
          res_vld = 1'b1;
          if (held_valid_r && (held_byte_r == xor_r)) begin
            res_kind = KIND_ACCEPT;
            res_seq  = frame_seq_r;
          end else begin
            res_kind = KIND_REJECT;
            res_seq  = ~frame_seq_r;
          end
          held_byte_nxt  = 8'd0;
          held_valid_nxt = 1'b0;
          xor_nxt        = 8'd0;
        end else if (!item.is_esc) begin
          take = 1'b1;
        end
      end
      PH_ESC: begin
        if (item.is_esc_flag) begin
          take      = 1'b1;
          take_byte = FLAG_BYTE;
        end else if (item.is_esc_esc) begin
          take      = 1'b1;
          take_byte = ESC_BYTE;
        end else begin
          res_vld        = 1'b1;
          res_kind       = KIND_BAD_ESC;
          held_byte_nxt  = 8'd0;
          held_valid_nxt = 1'b0;
          xor_nxt        = 8'd0;
        end
      end
      default: begin
      end
    endcase
    // A data byte releases the held one and takes its place.
    if (take) begin
      if (held_valid_r) begin
        res_vld  = 1'b1;
        res_kind = KIND_PAYLOAD;
        res_byte = held_byte_r;
        xor_nxt  = xor_r ^ held_byte_r;
      end
      held_byte_nxt  = take_byte;
      held_valid_nxt = 1'b1;
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      frame_seq_r  <= 1'b0;
      held_byte_r  <= 8'd0;
      held_valid_r <= 1'b0;
      xor_r        <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      if (pop) begin
        frame_seq_r  <= frame_seq_nxt;
        held_byte_r  <= held_byte_nxt;
        held_valid_r <= held_valid_nxt;
        xor_r        <= xor_nxt;
      end
    end
  end

  // Result register occupancy.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (pop && res_vld) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop && res_vld) begin
      kind_r <= res_kind;
      byte_r <= res_byte;
      seq_r  <= res_seq;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_result_kind  = kind_r;
  assign out_payload_byte = byte_r;
  assign out_reply_seq    = seq_r;

  `IFR_ASSERT_ALWAYS(a_held_in_frame,
                     held_valid_r |-> (phase_r == PH_DATA || phase_r == PH_ESC))
  `IFR_ASSERT(a_payload_has_held,
              (pop && res_vld && res_kind == KIND_PAYLOAD) |-> held_valid_r)
  `IFR_ASSERT(a_result_loaded, (pop && res_vld) |=> out_vld_r)

endmodule

FILE: src/info_frame_receiver.sv
// ----------------------------------------------------------------------------
// info_frame_receiver: byte-serial information frame deframer.
// Hunts for flag, address, control and header check, removes byte stuffing,
// checks the block check and reports accept, reject or a bad escape.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_rx_byte
//   out      output     out_valid / out_ready  out_result_kind,
//                                              out_payload_byte, out_reply_seq
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle unless the output stalls; the byte state machine
// in the back end does all work for an item as it pops it, so the rate is one
// item a cycle. A result is loaded into the input register at its byte
// transfer, then into a queue entry and then into the result register, which
// presents it.
// Reset is synchronous and active low and needs no clearing pass.
// A stalled output fills the queue and then drops in_ready; cfg_ready is
// always high.
// ----------------------------------------------------------------------------
module info_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_payload_byte,
  output logic       out_reply_seq,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import ifr_pkg::*;

  ifr_cfg_t  cfg_r;
  ifr_cfg_t  cfg_nxt;
  logic      f_vld;
  logic      f_ready;
  ifr_item_t f_item;
  logic      q_vld;
  logic      q_ready;
  ifr_item_t q_item;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ADDRESS:  cfg_nxt.address  = cfg_data;
        CFG_SEQ_ZERO: cfg_nxt.seq_zero = cfg_data;
        CFG_SEQ_ONE:  cfg_nxt.seq_one  = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.address  <= RST_ADDRESS;
      cfg_r.seq_zero <= RST_SEQ_ZERO;
      cfg_r.seq_one  <= RST_SEQ_ONE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: accept and classify.
  ifr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .item_vld   (f_vld),
    .item_ready (f_ready),
    .item       (f_item)
  );

  // Queue between the two halves.
  ifr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_vld   (f_vld),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_vld    (q_vld),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Back end: frame state machine and results.
  ifr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .item_vld         (q_vld),
    .item_ready       (q_ready),
    .item             (q_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_payload_byte (out_payload_byte),
    .out_reply_seq    (out_reply_seq)
  );

endmodule
